FILE: hdl/octave_value_noise_2d_defines.svh
// assertion macros for the octave value noise block
`ifndef OCTAVE_VALUE_NOISE_2D_DEFINES_SVH
`define OCTAVE_VALUE_NOISE_2D_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define OVN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ovn assertion failed");
`define OVN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ovn assertion failed");
`else
`define OVN_ASSERT(lbl, prop)
`define OVN_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/ovn_pkg.sv
// package: types, constants, curve table and blend function for the noise block
`timescale 1ns / 1ps

package ovn_pkg;

  localparam int OCTAVES    = 4;
  localparam int CURVE_BITS = 8;
  localparam int NUM_PRIMES = 6;
  localparam int CURVE_SIZE = 1 << CURVE_BITS;
  localparam int LATENCY    = 9;
  localparam int SW         = 36;
  localparam int CFG_AW     = 5;
  localparam int TAYLOR_N   = 12;

  typedef logic [31:0] word_t;
  typedef word_t prime_arr_t [NUM_PRIMES];
  typedef logic signed [SW-1:0] smooth_t;
  typedef logic [CURVE_BITS-1:0] curve_idx_t;
  typedef logic [16:0] weight_t;
  typedef weight_t curve_rom_t [CURVE_SIZE];
  typedef logic [63:0] dw_t;
  typedef dw_t taylor_div_t [TAYLOR_N];

  typedef struct packed {
    word_t pa;
    word_t pb;
    word_t pc;
  } hash_coef_t;

  localparam prime_arr_t PRIME_RESET = '{
    32'd15731, 32'd789221, 32'd1376312589, 32'd15733, 32'd789227, 32'd1376312627
  };

  localparam dw_t PI_Q30 = 64'd3373259426;

  function automatic taylor_div_t taylor_divs();
    taylor_div_t d;
    for (int n = 1; n <= TAYLOR_N; n++) begin
      d[n-1] = dw_t'(2 * n) * dw_t'(2 * n + 1);
    end
    return d;
  endfunction

  localparam taylor_div_t TaylorDiv = taylor_divs();

  // sin^2 table from a fixed q30 series
  function automatic curve_rom_t build_curve();
    curve_rom_t rom;
    dw_t theta;
    dw_t term;
    dw_t pos;
    dw_t neg;
    dw_t s;
    dw_t sq;
    dw_t w;
    for (int i = 0; i < CURVE_SIZE; i++) begin
      theta = (PI_Q30 * dw_t'(i)) >> (CURVE_BITS + 1);
      term  = theta;
      pos   = theta;
      neg   = '0;
      for (int n = 1; n <= TAYLOR_N; n++) begin
        term = (term * theta) >> 30;
        term = (term * theta) >> 30;
        term = term / TaylorDiv[n-1];
        if ((n % 2) == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      s  = (pos > neg) ? pos - neg : '0;
      sq = (s * s) >> 30;
      w  = (sq + 64'd8192) >> 14;
      if (w > 64'd65536) begin
        w = 64'd65536;
      end
      rom[i] = w[16:0];
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_curve();

  function automatic smooth_t blend(smooth_t a, smooth_t b, weight_t w);
    logic signed [54:0] acc;
    logic signed [17:0] wa;
    logic signed [17:0] wb;
    wa  = $signed({1'b0, 17'd65536 - w});
    wb  = $signed({1'b0, w});
    acc = 55'(a) * 55'(wa) + 55'(b) * 55'(wb);
    return smooth_t'(acc >>> 16);
  endfunction

endpackage

FILE: hdl/octave_value_noise_2d.sv
// top level: config registers, input stage, octave pipelines, octave sum
//
// fractal 2d value noise, one sample per transaction
// input: pulse start with x_coord_i / y_coord_i (signed q16.16); a transaction
//   is taken when start is high and busy is low; busy is always low, so a new
//   sample may enter every cycle
// output: noise_valid_o is high for one cycle with noise_value_o (signed
//   q3.28); the receiver cannot stall and results come in input order
// strobe path: input, lattice hash, smoothing, blend and output registers
// throughput: 1 sample per cycle; the depth is set by the three chained
//   multiplies of the lattice hash, the smoothing adder and two blend stages
// config: apb port, prime_0..prime_5 at byte addresses 0..20; the user writes
//   them only while no transaction is in flight, unenforced; pready is always high
// reset: clears the valid pipeline and restores the prime words; there is no
//   clearing pass and the block takes samples right after reset
`timescale 1ns / 1ps
`include "octave_value_noise_2d_defines.svh"

module octave_value_noise_2d (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         x_coord_i,
  input  logic signed [31:0]         y_coord_i,
  output logic                       noise_valid_o,
  output logic signed [31:0]         noise_value_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ovn_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

  ovn_pkg::prime_arr_t prime_q;
  logic [2:0] cfg_idx;
  logic cfg_wr;
  logic [ovn_pkg::LATENCY-1:0] vld_d, vld_q;
  ovn_pkg::word_t x_q, y_q;
  ovn_pkg::smooth_t oct_val [ovn_pkg::OCTAVES];
  logic signed [33:0] sum_d;
  logic signed [31:0] out_d, out_q;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (32'(cfg_idx) < ovn_pkg::NUM_PRIMES) begin
      prdata = prime_q[cfg_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= ovn_pkg::PRIME_RESET;
    end else if (cfg_wr && (32'(cfg_idx) < ovn_pkg::NUM_PRIMES)) begin
      prime_q[cfg_idx] <= pwdata;
    end
  end

  assign vld_d = {vld_q[ovn_pkg::LATENCY-2:0], start && !busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_coord_i;
    y_q   <= y_coord_i;
    out_q <= out_d;
  end

  for (genvar k = 0; k < ovn_pkg::OCTAVES; k++) begin : g_oct
    localparam int IA = k % ovn_pkg::NUM_PRIMES;
    localparam int IB = (k + 1) % ovn_pkg::NUM_PRIMES;
    localparam int IC = (k + 2) % ovn_pkg::NUM_PRIMES;
    ovn_pkg::hash_coef_t coef;
    assign coef = '{pa: prime_q[IA], pb: prime_q[IB], pc: prime_q[IC]};
    ovn_octave u_octave (
      .clk_i   (clk_i),
      .x_i     (x_q),
      .y_i     (y_q),
      .oct_i   (3'(k)),
      .coef_i  (coef),
      .value_o (oct_val[k])
    );
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < ovn_pkg::OCTAVES; k++) begin
      sum_d = sum_d + 34'(oct_val[k] >>> (6 + 2 * k));
    end
    if (sum_d > SAT_MAX) begin
      out_d = SAT_MAX[31:0];
    end else if (sum_d < SAT_MIN) begin
      out_d = SAT_MIN[31:0];
    end else begin
      out_d = sum_d[31:0];
    end
  end

  assign noise_valid_o = vld_q[ovn_pkg::LATENCY-1];
  assign noise_value_o = out_q;

  `OVN_ASSERT(a_latency, (start && !busy) |-> ##9 noise_valid_o)
  `OVN_ASSERT(a_no_sat, vld_q[ovn_pkg::LATENCY-2] |-> (sum_d <= SAT_MAX && sum_d >= SAT_MIN))
  `OVN_ASSERT_NEXT(a_cfg_wr, cfg_wr && cfg_idx == 3'd0, prime_q[0] == $past(pwdata))

endmodule

FILE: hdl/ovn_hash.sv
// lattice hash pipeline: four register stages from lattice index to lattice value
`timescale 1ns / 1ps

module ovn_hash (
  input  logic                clk_i,
  input  ovn_pkg::word_t      x_i,
  input  ovn_pkg::word_t      y_i,
  input  ovn_pkg::hash_coef_t coef_i,
  output logic signed [31:0]  lat_o
);

  ovn_pkg::word_t n_d, n_q;
  ovn_pkg::word_t sq_d, sq_q, n2_q;
  ovn_pkg::word_t t2_d, t2_q, n3_q;
  ovn_pkg::word_t m_d;
  logic signed [31:0] lat_d, lat_q;

  always_comb begin
    n_d   = x_i + ovn_pkg::word_t'(32'd57 * y_i);
    sq_d  = ovn_pkg::word_t'(n_q * n_q);
    t2_d  = ovn_pkg::word_t'(sq_q * coef_i.pa) + coef_i.pb;
    m_d   = ovn_pkg::word_t'(n3_q * t2_q) + coef_i.pc;
    lat_d = $signed(32'h4000_0000 - {1'b0, m_d[30:0]});
  end

  always_ff @(posedge clk_i) begin
    n_q   <= (n_d << 13) ^ n_d;
    sq_q  <= sq_d;
    n2_q  <= n_q;
    t2_q  <= t2_d;
    n3_q  <= n2_q;
    lat_q <= lat_d;
  end

  assign lat_o = lat_q;

endmodule

FILE: hdl/ovn_octave.sv
// one octave: 4x4 lattice hashes, 3x3 smoothing, two cosine blend stages
`timescale 1ns / 1ps

module ovn_octave (
  input  logic                clk_i,
  input  ovn_pkg::word_t      x_i,
  input  ovn_pkg::word_t      y_i,
  input  logic [2:0]          oct_i,
  input  ovn_pkg::hash_coef_t coef_i,
  output ovn_pkg::smooth_t    value_o
);

  logic [47:0] xs, ys;
  ovn_pkg::word_t xi, yi;
  logic signed [31:0] lat [4][4];
  ovn_pkg::curve_idx_t fx_q [6];
  ovn_pkg::curve_idx_t fy_q [6];
  ovn_pkg::smooth_t s_d [2][2];
  ovn_pkg::smooth_t s_q [2][2];
  ovn_pkg::smooth_t bx_d [2];
  ovn_pkg::smooth_t bx_q [2];
  ovn_pkg::smooth_t by_d, by_q;
  ovn_pkg::weight_t wx, wy;

  always_comb begin
    xs = {{16{x_i[31]}}, x_i} << oct_i;
    ys = {{16{y_i[31]}}, y_i} << oct_i;
    xi = xs[47:16];
    yi = ys[47:16];
  end

  for (genvar j = 0; j < 4; j++) begin : g_row
    for (genvar i = 0; i < 4; i++) begin : g_col
      ovn_hash u_hash (
        .clk_i  (clk_i),
        .x_i    (xi + ovn_pkg::word_t'(i) - 32'd1),
        .y_i    (yi + ovn_pkg::word_t'(j) - 32'd1),
        .coef_i (coef_i),
        .lat_o  (lat[j][i])
      );
    end
  end

  // smoothed cell corners
  for (genvar cy = 0; cy < 2; cy++) begin : g_sy
    for (genvar cx = 0; cx < 2; cx++) begin : g_sx
      always_comb begin
        s_d[cy][cx] =
          (ovn_pkg::smooth_t'(lat[cy+1][cx+1]) <<< 2)
          + ((ovn_pkg::smooth_t'(lat[cy+1][cx]) + ovn_pkg::smooth_t'(lat[cy+1][cx+2])
            + ovn_pkg::smooth_t'(lat[cy][cx+1]) + ovn_pkg::smooth_t'(lat[cy+2][cx+1])) <<< 1)
          + ovn_pkg::smooth_t'(lat[cy][cx]) + ovn_pkg::smooth_t'(lat[cy][cx+2])
          + ovn_pkg::smooth_t'(lat[cy+2][cx]) + ovn_pkg::smooth_t'(lat[cy+2][cx+2]);
      end
    end
  end

  always_comb begin
    wx      = ovn_pkg::CURVE_ROM[fx_q[4]];
    wy      = ovn_pkg::CURVE_ROM[fy_q[5]];
    bx_d[0] = ovn_pkg::blend(s_q[0][0], s_q[0][1], wx);
    bx_d[1] = ovn_pkg::blend(s_q[1][0], s_q[1][1], wx);
    by_d    = ovn_pkg::blend(bx_q[0], bx_q[1], wy);
  end

  always_ff @(posedge clk_i) begin
    fx_q[0] <= xs[15 -: ovn_pkg::CURVE_BITS];
    fy_q[0] <= ys[15 -: ovn_pkg::CURVE_BITS];
    for (int p = 1; p < 6; p++) begin
      fx_q[p] <= fx_q[p-1];
      fy_q[p] <= fy_q[p-1];
    end
    s_q  <= s_d;
    bx_q <= bx_d;
    by_q <= by_d;
  end

  assign value_o = by_q;

endmodule

FILE: tb/octave_value_noise_2d_tb.sv
// testbench for the octave value noise block: directed and random samples against a predictor
`timescale 1ns / 1ps

module octave_value_noise_2d_tb;

  typedef enum logic [ovn_pkg::CFG_AW-1:0] {
    REG_PRIME_0 = 5'd0,
    REG_PRIME_1 = 5'd4,
    REG_PRIME_2 = 5'd8,
    REG_PRIME_3 = 5'd12,
    REG_PRIME_4 = 5'd16,
    REG_PRIME_5 = 5'd20
  } reg_addr_e;

  localparam int WATCHDOG_LIMIT = 2000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic signed [31:0]          x_coord_i;
  logic signed [31:0]          y_coord_i;
  logic                        noise_valid_o;
  logic signed [31:0]          noise_value_o;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ovn_pkg::CFG_AW-1:0]  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  logic [31:0]         hash_words [ovn_pkg::NUM_PRIMES];
  logic [16:0]         cos_curve [ovn_pkg::CURVE_SIZE];
  logic signed [31:0]  noise_expected [$];
  int                  fail_count;
  int                  sample_count;
  int                  noise_count;
  int                  idle_cycles;
  bit                  allow_gaps;

  octave_value_noise_2d u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .noise_valid_o (noise_valid_o),
    .noise_value_o (noise_value_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic longint floor_div_pow2(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic void make_cos_curve();
    longint unsigned theta, term, pos, neg, s, sq, w;
    for (int i = 0; i < ovn_pkg::CURVE_SIZE; i++) begin
      theta = (64'd3373259426 * longint'(i)) >> (ovn_pkg::CURVE_BITS + 1);
      term = theta;
      pos = theta;
      neg = 0;
      for (int n = 1; n <= 12; n++) begin
        term = (term * theta) >> 30;
        term = (term * theta) >> 30;
        term = term / (longint'(2 * n) * longint'(2 * n + 1));
        if (n % 2 == 1) neg += term;
        else pos += term;
      end
      s = (pos > neg) ? pos - neg : 0;
      sq = (s * s) >> 30;
      w = (sq + 8192) >> 14;
      if (w > 65536) w = 65536;
      cos_curve[i] = w[16:0];
    end
  endfunction

  function automatic longint hash_value(logic [31:0] xi, logic [31:0] yi, int k);
    logic [31:0] pa, pb, pc, n, m;
    pa = hash_words[k % ovn_pkg::NUM_PRIMES];
    pb = hash_words[(k + 1) % ovn_pkg::NUM_PRIMES];
    pc = hash_words[(k + 2) % ovn_pkg::NUM_PRIMES];
    n = xi + 32'd57 * yi;
    n = (n << 13) ^ n;
    m = (n * (n * n * pa + pb) + pc) & 32'h7fffffff;
    return 64'sd1073741824 - longint'({32'd0, m});
  endfunction

  function automatic longint smoothed(logic [31:0] xi, logic [31:0] yi, int k);
    longint c, sd, cr;
    c = hash_value(xi, yi, k);
    sd = hash_value(xi - 1, yi, k) + hash_value(xi + 1, yi, k)
       + hash_value(xi, yi + 1, k) + hash_value(xi, yi - 1, k);
    cr = hash_value(xi - 1, yi - 1, k) + hash_value(xi + 1, yi - 1, k)
       + hash_value(xi - 1, yi + 1, k) + hash_value(xi + 1, yi + 1, k);
    return 4 * c + 2 * sd + cr;
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    return floor_div_pow2(a * (65536 - w) + b * w, 16);
  endfunction

  function automatic logic signed [31:0] noise_of(logic signed [31:0] x,
                                                  logic signed [31:0] y);
    longint total, sx, sy, wx, wy, bl, br, tl, tr, v;
    logic [31:0] xi, yi;
    total = 0;
    for (int k = 0; k < ovn_pkg::OCTAVES; k++) begin
      sx = longint'(x) <<< k;
      sy = longint'(y) <<< k;
      xi = 32'(floor_div_pow2(sx, 16));
      yi = 32'(floor_div_pow2(sy, 16));
      wx = cos_curve[sx[15:16-ovn_pkg::CURVE_BITS]];
      wy = cos_curve[sy[15:16-ovn_pkg::CURVE_BITS]];
      bl = smoothed(xi, yi, k);
      br = smoothed(xi + 1, yi, k);
      tl = smoothed(xi, yi + 1, k);
      tr = smoothed(xi + 1, yi + 1, k);
      v = mix(mix(bl, br, wx), mix(tl, tr, wx), wy);
      total += floor_div_pow2(v, 6 + 2 * k);
    end
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    return total[31:0];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && noise_valid_o) begin
      noise_count <= noise_count + 1;
      if (noise_expected.size() == 0) begin
        $display("%0t: unexpected noise transaction, expected none, actual %h",
                 $time, noise_value_o);
        fail_count <= fail_count + 1;
      end else begin
        if (noise_value_o !== noise_expected[0]) begin
          $display("%0t: noise_value mismatch, expected %h, actual %h",
                   $time, noise_expected[0], noise_value_o);
          fail_count <= fail_count + 1;
        end
        void'(noise_expected.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || noise_valid_o || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic idle_burst();
    int n;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_sample(logic signed [31:0] x, logic signed [31:0] y);
    idle_burst();
    start <= 1'b1;
    x_coord_i <= x;
    y_coord_i <= y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    noise_expected.push_back(noise_of(x, y));
    sample_count++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (noise_expected.size() != 0) @(posedge clk_i);
    repeat (ovn_pkg::LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_prime(reg_addr_e addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    hash_words[addr / 4] = value;
    @(posedge clk_i);
  endtask

  task automatic load_primes(logic [31:0] p0, logic [31:0] p1, logic [31:0] p2,
                             logic [31:0] p3, logic [31:0] p4, logic [31:0] p5);
    write_prime(REG_PRIME_0, p0);
    write_prime(REG_PRIME_1, p1);
    write_prime(REG_PRIME_2, p2);
    write_prime(REG_PRIME_3, p3);
    write_prime(REG_PRIME_4, p4);
    write_prime(REG_PRIME_5, p5);
  endtask

  task automatic test_extremes();
    logic signed [31:0] pts [10];
    pts = '{32'sh80000000, 32'sh7fffffff, 32'sh00000000, 32'shffffffff,
            32'sh00010000, 32'shffff0000, 32'sh0000ffff, 32'sh00008000,
            32'sh40000000, 32'shc0000001};
    foreach (pts[i]) send_sample(pts[i], pts[(i * 3 + 1) % 10]);
    for (int i = 0; i < 10; i++) send_sample(pts[i], pts[i]);
    drain();
  endtask

  task automatic test_random(int n, bit small_range);
    logic signed [31:0] x, y;
    for (int i = 0; i < n; i++) begin
      x = $urandom;
      y = $urandom;
      if (small_range && $urandom_range(0, 1)) begin
        x = $signed(x) >>> 12;
        y = $signed(y) >>> 12;
      end
      send_sample(x, y);
    end
    drain();
  endtask

  task automatic test_prime_settings();
    load_primes(32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff, 32'h1, 32'h80000000);
    test_random(150, 1'b1);
    load_primes(32'hffffffff, 32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0);
    test_random(150, 1'b0);
    load_primes($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    test_random(200, 1'b1);
  endtask

  initial begin
    start = 1'b0;
    x_coord_i = '0;
    y_coord_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    sample_count = 0;
    noise_count = 0;
    idle_cycles = 0;
    allow_gaps = 1'b1;
    hash_words = ovn_pkg::PRIME_RESET;
    make_cos_curve();
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_random(500, 1'b1);
    test_prime_settings();
    load_primes(32'd15731, 32'd789221, 32'd1376312589, 32'd15733, 32'd789227,
                32'd1376312627);
    allow_gaps = 1'b0;
    test_random(500, 1'b0);

    $display("covered %0d samples with %0d noise results, coordinate extremes,",
             sample_count, noise_count);
    $display("reset, extreme and random hash words, with and without input gaps");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ovn_pkg.sv
hdl/ovn_hash.sv
hdl/ovn_octave.sv
hdl/octave_value_noise_2d.sv
tb/octave_value_noise_2d_tb.sv
